>>> hdl/telnet_option_negotiator_top_defines.svh
// assertion macros for the telnet option negotiator checker
`ifndef TELNET_OPTION_NEGOTIATOR_TOP_DEFINES_SVH
`define TELNET_OPTION_NEGOTIATOR_TOP_DEFINES_SVH

// property checked outside reset
`define TNON_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked also across reset
`define TNON_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/tnon_pkg.sv
// shared types and constants of the telnet option negotiator
`timescale 1ns / 1ps
`default_nettype none
package tnon_pkg;

  localparam logic [7:0] IAC_BYTE  = 8'hFF;
  localparam logic [7:0] VERB_DO   = 8'hFD;
  localparam logic [7:0] VERB_WONT = 8'hFC;
  localparam logic [7:0] VERB_WILL = 8'hFB;
  localparam logic [7:0] VERB_SB   = 8'hFA;
  localparam logic [7:0] VERB_SE   = 8'hF0;
  localparam logic [7:0] OPT_NAWS  = 8'd31;

  localparam logic [15:0] COLUMNS_RESET = 16'd80;
  localparam logic [15:0] ROWS_RESET    = 16'd24;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS    = 1'b1;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_VERB   = 2'd1,
    PH_OPTION = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    JOB_DATA  = 2'd0,
    JOB_REPLY = 2'd1,
    JOB_NAWS  = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] verb;
    logic [7:0] opt;
  } job_t;

endpackage
`default_nettype wire

>>> hdl/telnet_option_negotiator_top.sv
// top level of the telnet option negotiator
`timescale 1ns / 1ps
`default_nettype none
// Parses a received telnet byte stream, one item per cycle while in_stall is low,
// into a one-deep job register. A data byte gives one result and, while out_stall
// is low, the block keeps one item per cycle for a stream of them. An IAC or verb
// byte gives no result. An option byte gives a three-byte reply, or for DO
// WINDOW_SIZE a twelve-byte reply; the job register holds that reply while its
// bytes go out one per cycle unless out_stall holds them, and in_stall stays high
// until its last byte enters the output register. An accepted item passes
// through the job register and then the output register. The window size
// registers, written on cfg_we, apply to window size bytes loaded afterwards.
module telnet_option_negotiator_top
  import tnon_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_rx_byte,
  input  wire logic                 in_chunk_end,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_to_peer,
  output logic [7:0]                out_out_byte,
  output logic                      out_message_end,
  output logic                      out_last,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_wdata
);

  logic        in_fire;
  logic        can_take;
  logic        job_valid;
  job_t        job;
  logic [15:0] columns_r;
  logic [15:0] rows_r;

  assign in_stall = !can_take;
  assign in_fire  = in_valid && can_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLUMNS_RESET;
      rows_r    <= ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_COLUMNS: columns_r <= cfg_wdata;
        CFG_IDX_ROWS:    rows_r    <= cfg_wdata;
      endcase
    end
  end

  tnon_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .rx_byte   (in_rx_byte),
    .job_valid (job_valid),
    .job       (job)
  );

  tnon_emitter u_emitter (
    .clk             (clk),
    .rst_n           (rst_n),
    .new_valid       (in_fire && job_valid),
    .new_job         (job),
    .can_take        (can_take),
    .columns         (columns_r),
    .rows            (rows_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_to_peer     (out_to_peer),
    .out_out_byte    (out_out_byte),
    .out_message_end (out_message_end),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

>>> hdl/tnon_parser.sv
// three-phase command parser turning accepted bytes into output jobs
`timescale 1ns / 1ps
`default_nettype none
module tnon_parser
  import tnon_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic [7:0] rx_byte,
  output logic            job_valid,
  output job_t            job
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_verb_r, held_verb_nxt;
  logic [7:0] mapped_verb;
  logic       is_naws;

  // next phase
  always_comb begin
    case (phase_r)
      PH_VERB:   phase_nxt = PH_OPTION;
      PH_OPTION: phase_nxt = PH_NORMAL;
      default:   phase_nxt = (rx_byte == IAC_BYTE) ? PH_VERB : PH_NORMAL;
    endcase
  end

  always_comb begin
    priority if (held_verb_r == VERB_DO) begin
      mapped_verb = VERB_WONT;
    end else if (held_verb_r == VERB_WILL) begin
      mapped_verb = VERB_DO;
    end else begin
      mapped_verb = held_verb_r;
    end
  end

  assign is_naws = (held_verb_r == VERB_DO) && (rx_byte == OPT_NAWS);

  // job and held verb
  always_comb begin
    held_verb_nxt = held_verb_r;
    job.kind      = JOB_DATA;
    job.verb      = held_verb_r;
    job.opt       = rx_byte;
    job_valid     = 1'b0;
    case (phase_r)
      PH_VERB: begin
        held_verb_nxt = rx_byte;
      end
      PH_OPTION: begin
        job_valid = 1'b1;
        if (is_naws) begin
          job.kind = JOB_NAWS;
        end else begin
          job.kind      = JOB_REPLY;
          job.verb      = mapped_verb;
          held_verb_nxt = mapped_verb;
        end
      end
      default: begin
        job_valid = (rx_byte != IAC_BYTE);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_NORMAL;
      held_verb_r <= 8'h00;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      held_verb_r <= held_verb_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/tnon_emitter.sv
// job register, byte sequencer and output register
`timescale 1ns / 1ps
`default_nettype none
module tnon_emitter
  import tnon_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        new_valid,
  input  wire job_t        new_job,
  output logic             can_take,
  input  wire logic [15:0] columns,
  input  wire logic [15:0] rows,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_to_peer,
  output logic [7:0]       out_out_byte,
  output logic             out_message_end,
  output logic             out_last
);

  logic       busy_r;
  job_t       job_r;
  logic [3:0] idx_r;
  logic [3:0] last_idx;
  logic       out_load;
  logic       job_done;
  logic [7:0] byte_sel;
  logic       msg_end_sel;

  logic       out_valid_r;
  logic       to_peer_r;
  logic [7:0] byte_r;
  logic       msg_end_r;
  logic       last_r;

  always_comb begin
    unique case (job_r.kind)
      JOB_REPLY: last_idx = 4'd2;
      JOB_NAWS:  last_idx = 4'd11;
      default:   last_idx = 4'd0;
    endcase
  end

  assign out_load = busy_r && (!out_valid_r || !out_stall);
  assign job_done = out_load && (idx_r == last_idx);
  assign can_take = !busy_r || job_done;

  // byte of the current job at the current position
  always_comb begin
    byte_sel    = job_r.opt;
    msg_end_sel = 1'b0;
    unique case (job_r.kind)
      JOB_REPLY: begin
        msg_end_sel = (idx_r == 4'd2);
        case (idx_r)
          4'd0:    byte_sel = IAC_BYTE;
          4'd1:    byte_sel = job_r.verb;
          default: byte_sel = job_r.opt;
        endcase
      end
      JOB_NAWS: begin
        msg_end_sel = (idx_r == 4'd2) || (idx_r == 4'd11);
        case (idx_r)
          4'd0:    byte_sel = IAC_BYTE;
          4'd1:    byte_sel = VERB_WILL;
          4'd2:    byte_sel = OPT_NAWS;
          4'd3:    byte_sel = IAC_BYTE;
          4'd4:    byte_sel = VERB_SB;
          4'd5:    byte_sel = OPT_NAWS;
          4'd6:    byte_sel = columns[15:8];
          4'd7:    byte_sel = columns[7:0];
          4'd8:    byte_sel = rows[15:8];
          4'd9:    byte_sel = rows[7:0];
          4'd10:   byte_sel = IAC_BYTE;
          default: byte_sel = VERB_SE;
        endcase
      end
      default: begin
        byte_sel    = job_r.opt;
        msg_end_sel = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 4'd0;
    end else if (new_valid) begin
      busy_r <= 1'b1;
      idx_r  <= 4'd0;
    end else if (job_done) begin
      busy_r <= 1'b0;
      idx_r  <= 4'd0;
    end else if (out_load) begin
      idx_r <= idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (new_valid) begin
      job_r <= new_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      to_peer_r <= (job_r.kind != JOB_DATA);
      byte_r    <= byte_sel;
      msg_end_r <= msg_end_sel;
      last_r    <= (idx_r == last_idx);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_to_peer     = to_peer_r;
  assign out_out_byte    = byte_r;
  assign out_message_end = msg_end_r;
  assign out_last        = last_r;

endmodule
`default_nettype wire

>>> hdl/tnon_checker.sv
// port-level checker for the telnet option negotiator and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "telnet_option_negotiator_top_defines.svh"
module tnon_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_to_peer,
  input wire logic [7:0] out_out_byte,
  input wire logic       out_message_end,
  input wire logic       out_last
);

  `TNON_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_out_byte), "stalled result changed")
  `TNON_ASSERT(a_data_single, out_valid && !out_to_peer |-> out_last && !out_message_end, "application item not single")
  `TNON_ASSERT(a_last_ends_msg, out_valid && out_to_peer && out_last |-> out_message_end, "reply last without message end")
  `TNON_ASSERT_RST(a_reset_ready, !rst_n |=> !in_stall && !out_valid, "not idle after reset")

endmodule

bind telnet_option_negotiator_top tnon_checker u_tnon_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_to_peer     (out_to_peer),
  .out_out_byte    (out_out_byte),
  .out_message_end (out_message_end),
  .out_last        (out_last)
);
`default_nettype wire
